// File: rtl/laser_line_peak_search_top_assert.svh
// assertion macros for the peak search block, clocked on clk, reset by rst
`ifndef LASER_LINE_PEAK_SEARCH_TOP_ASSERT_SVH
`define LASER_LINE_PEAK_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define LLPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("llps check failed");
// checked during reset too
`define LLPS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("llps check failed");
`else
`define LLPS_ASSERT(name, prop)
`define LLPS_ASSERT_ALWAYS(name, prop)
`endif

`endif

// File: rtl/llps_pkg.sv
`timescale 1ns / 1ps
package llps_pkg;

  localparam int MAX_DIM_DEF = 2048;
  localparam int PIX_W       = 8;
  localparam int STEP_W      = 8;
  localparam int SIZE_W      = 12;
  localparam int LINE_OUT_W  = 11;
  localparam int POS_W       = 12;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_HORIZONTAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd6;

  // register reset values
  localparam logic [PIX_W-1:0]  RST_THRESHOLD      = 8'd230;
  localparam logic [SIZE_W-1:0] RST_MAX_LINE_WIDTH = 12'd20;
  localparam logic [STEP_W-1:0] RST_STEP_X         = 8'd10;
  localparam logic [STEP_W-1:0] RST_STEP_Y         = 8'd1;
  localparam logic              RST_MAIN_HORIZ     = 1'b1;
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH    = 12'd2048;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT   = 12'd2048;

  typedef struct packed {
    logic sampled;
    logic is_first;
    logic is_last;
    logic frame_end;
  } scan_flags_t;

  typedef struct packed {
    logic                  frame_last;
    logic                  found;
    logic [POS_W-1:0]      position_x2;
    logic [LINE_OUT_W-1:0] line_index;
  } result_t;

  function automatic logic [STEP_W-1:0] next_phase(input logic [STEP_W-1:0] p,
                                                   input logic [STEP_W-1:0] s);
    logic [STEP_W:0] inc;
    inc = {1'b0, p} + (STEP_W + 1)'(1);
    return (inc >= {1'b0, s}) ? '0 : inc[STEP_W-1:0];
  endfunction

  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
    return (s == '0) ? STEP_W'(1) : s;
  endfunction

endpackage

// File: rtl/llps_scan.sv
`timescale 1ns / 1ps
module llps_scan #(
  parameter int MAX_DIM = llps_pkg::MAX_DIM_DEF,
  localparam int CW = $clog2(MAX_DIM),
  localparam int SW = (CW + 1 > 13) ? CW + 1 : 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      frame_start,
  input  logic [llps_pkg::STEP_W-1:0] step_x,
  input  logic [llps_pkg::STEP_W-1:0] step_y,
  input  logic [SW-1:0]             width,
  input  logic [SW-1:0]             height,
  input  logic                      main_horizontal,
  output logic [CW-1:0]             line,
  output logic [CW-1:0]             idx,
  output llps_pkg::scan_flags_t     flags
);
  import llps_pkg::*;

  logic [CW-1:0]     col, row, col_next, row_next;
  logic [STEP_W-1:0] cph, rph, cph_next, rph_next;
  logic [CW-1:0]     cur_col, cur_row;
  logic [STEP_W-1:0] cur_cph, cur_rph;
  logic              col_wrap, row_wrap, col_last, row_last;

  // a frame start puts this pixel at the origin
  assign cur_col = frame_start ? '0 : col;
  assign cur_row = frame_start ? '0 : row;
  assign cur_cph = frame_start ? '0 : cph;
  assign cur_rph = frame_start ? '0 : rph;

  assign col_wrap = (SW'(cur_col) + SW'(1)) >= width;
  assign row_wrap = (SW'(cur_row) + SW'(1)) >= height;
  assign col_last = (SW'(cur_col) + SW'(step_x)) >= width;
  assign row_last = (SW'(cur_row) + SW'(step_y)) >= height;

  always_comb begin
    flags.sampled = (cur_cph == '0) && (cur_rph == '0);
    if (main_horizontal) begin
      line            = cur_col;
      idx             = cur_row;
      flags.is_first  = (cur_row == '0);
      flags.is_last   = row_last;
      flags.frame_end = col_last;
    end else begin
      line            = cur_row;
      idx             = cur_col;
      flags.is_first  = (cur_col == '0);
      flags.is_last   = col_last;
      flags.frame_end = row_last;
    end
  end

  always_comb begin
    col_next = cur_col + CW'(1);
    row_next = cur_row;
    cph_next = next_phase(cur_cph, step_x);
    rph_next = cur_rph;
    if (col_wrap) begin
      col_next = '0;
      cph_next = '0;
      if (row_wrap) begin
        row_next = '0;
        rph_next = '0;
      end else begin
        row_next = cur_row + CW'(1);
        rph_next = next_phase(cur_rph, step_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cph <= '0;
      rph <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
      cph <= cph_next;
      rph <= rph_next;
    end
  end

endmodule

// File: rtl/llps_peak_store.sv
`timescale 1ns / 1ps
module llps_peak_store #(
  parameter int DEPTH = llps_pkg::MAX_DIM_DEF,
  parameter int DW    = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/llps_update.sv
`timescale 1ns / 1ps
module llps_update #(
  parameter int MAX_DIM = llps_pkg::MAX_DIM_DEF,
  localparam int CW = $clog2(MAX_DIM),
  localparam int SW = (CW + 1 > 13) ? CW + 1 : 13,
  localparam int DW = llps_pkg::PIX_W + 2 * CW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  output logic                        in_ready,
  input  logic [llps_pkg::PIX_W-1:0]  pixel,
  input  logic [CW-1:0]               line,
  input  logic [CW-1:0]               idx,
  input  llps_pkg::scan_flags_t       flags,
  input  logic [llps_pkg::PIX_W-1:0]  threshold,
  input  logic [llps_pkg::SIZE_W-1:0] max_line_width,
  input  logic [DW-1:0]               rd_data,
  output logic                        wr_en,
  output logic [CW-1:0]               wr_addr,
  output logic [DW-1:0]               wr_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output llps_pkg::result_t           result
);
  import llps_pkg::*;

  logic              s1_valid, s1_first, s1_last, s1_fend;
  logic [PIX_W-1:0]  s1_pix;
  logic [CW-1:0]     s1_line, s1_idx;
  logic              fwd_sel;
  logic [DW-1:0]     fwd_data;
  logic              go;
  logic [DW-1:0]     entry;
  logic [PIX_W-1:0]  peak, peak_next;
  logic [CW-1:0]     first, last, first_next, last_next, gap;
  logic [CW:0]       pos_sum;
  logic              found;

  assign go       = !out_valid || out_ready;
  assign in_ready = !s1_valid || go;

  // entry written on the edge that read it comes from the bypass
  assign entry = fwd_sel ? fwd_data : rd_data;
  assign peak  = entry[DW-1 -: PIX_W];
  assign first = entry[2*CW-1 -: CW];
  assign last  = entry[CW-1:0];
  assign gap   = (first > s1_idx) ? first - s1_idx : s1_idx - first;

  always_comb begin
    peak_next  = peak;
    first_next = first;
    last_next  = last;
    if (s1_first || (s1_pix > peak)) begin
      peak_next  = s1_pix;
      first_next = s1_idx;
      last_next  = s1_idx;
    end else if ((s1_pix == peak) && (SW'(gap) <= SW'(max_line_width))) begin
      last_next = s1_idx;
    end
  end

  assign pos_sum = {1'b0, first_next} + {1'b0, last_next};
  assign found   = peak_next > threshold;

  assign wr_en   = s1_valid && go;
  assign wr_addr = s1_line;
  assign wr_data = {peak_next, first_next, last_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= flags.sampled;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        out_valid <= s1_valid && s1_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && flags.sampled) begin
      s1_pix   <= pixel;
      s1_line  <= line;
      s1_idx   <= idx;
      s1_first <= flags.is_first;
      s1_last  <= flags.is_last;
      s1_fend  <= flags.frame_end;
      fwd_sel  <= wr_en && (wr_addr == line);
      fwd_data <= wr_data;
    end
    if (go && s1_valid && s1_last) begin
      result.line_index  <= LINE_OUT_W'(s1_line);
      result.position_x2 <= found ? POS_W'(pos_sum) : '0;
      result.found       <= found;
      result.frame_last  <= s1_fend;
    end
  end

endmodule

// File: rtl/laser_line_peak_search_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: pixel; tuser: frame_start
// m_*       out  m_tvalid/m_tready  tdata: line_index, position_x2; tuser: found;
//                                   tlast: frame_last
// cfg_*     in   cfg_we             cfg_index, cfg_data
//
// one pixel per clock while s_tready is high; results pass stage one, then the output register
// the rate is set by the single read port and single write port of the line store:
// one read-modify-write per cycle, a write and a read to the same entry meet in a bypass
// reset clears counters, pipeline valids and registers; the line store is not cleared,
// each entry is written on the first sampled pixel of its line
// s_tready drops only while a result sits in the output register and m_tready is low
module laser_line_peak_search_top #(
  parameter int MAX_DIM = llps_pkg::MAX_DIM_DEF,
  localparam int CW = $clog2(MAX_DIM),
  localparam int SW = (CW + 1 > 13) ? CW + 1 : 13
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave side
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [llps_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] pixel
  input  logic                            s_tuser,   // [0] frame_start
  // master side
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [llps_pkg::OUT_DATA_W-1:0] m_tdata,   // [10:0] line_index, [22:11] position_x2
  output logic                            m_tuser,   // [0] found
  output logic                            m_tlast,   // frame_last
  // configuration
  input  logic                            cfg_we,
  input  logic [llps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [llps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import llps_pkg::*;

  `include "laser_line_peak_search_top_assert.svh"

  localparam int DW = PIX_W + 2 * CW;

  // configuration registers
  logic [PIX_W-1:0]  threshold;
  logic [SIZE_W-1:0] max_line_width;
  logic [STEP_W-1:0] step_x, step_y;
  logic              main_horizontal;
  logic [SIZE_W-1:0] image_width, image_height;

  logic [STEP_W-1:0] step_x_eff, step_y_eff;
  logic [SW-1:0]     width_eff, height_eff;

  logic              accept, ready;
  logic [CW-1:0]     line, idx;
  scan_flags_t       flags;
  logic [DW-1:0]     rd_data, wr_data;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  result_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= RST_THRESHOLD;
      max_line_width  <= RST_MAX_LINE_WIDTH;
      step_x          <= RST_STEP_X;
      step_y          <= RST_STEP_Y;
      main_horizontal <= RST_MAIN_HORIZ;
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:       threshold       <= cfg_data[PIX_W-1:0];
        CFG_MAX_LINE_WIDTH:  max_line_width  <= cfg_data;
        CFG_STEP_X:          step_x          <= cfg_data[STEP_W-1:0];
        CFG_STEP_Y:          step_y          <= cfg_data[STEP_W-1:0];
        CFG_MAIN_HORIZONTAL: main_horizontal <= cfg_data[0];
        CFG_IMAGE_WIDTH:     image_width     <= cfg_data;
        CFG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero step acts as one; sizes are held between one and the store depth
  assign step_x_eff = eff_step(step_x);
  assign step_y_eff = eff_step(step_y);

  always_comb begin
    width_eff = SW'(image_width);
    if (image_width == '0) begin
      width_eff = SW'(1);
    end else if (SW'(image_width) > SW'(MAX_DIM)) begin
      width_eff = SW'(MAX_DIM);
    end
    height_eff = SW'(image_height);
    if (image_height == '0) begin
      height_eff = SW'(1);
    end else if (SW'(image_height) > SW'(MAX_DIM)) begin
      height_eff = SW'(MAX_DIM);
    end
  end

  assign s_tready = ready;
  assign accept   = s_tvalid && ready;

  // raster position, sampling phases and line/index selection
  llps_scan #(.MAX_DIM(MAX_DIM)) u_scan (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .frame_start    (s_tuser),
    .step_x         (step_x_eff),
    .step_y         (step_y_eff),
    .width          (width_eff),
    .height         (height_eff),
    .main_horizontal(main_horizontal),
    .line           (line),
    .idx            (idx),
    .flags          (flags)
  );

  // per line peak, first and last index; read issued as a sampled item is taken
  llps_peak_store #(.DEPTH(MAX_DIM), .DW(DW)) u_store (
    .clk    (clk),
    .rd_en  (accept && flags.sampled),
    .rd_addr(line),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // compare and write back, result register
  llps_update #(.MAX_DIM(MAX_DIM)) u_update (
    .clk           (clk),
    .rst           (rst),
    .take          (accept),
    .in_ready      (ready),
    .pixel         (s_tdata[PIX_W-1:0]),
    .line          (line),
    .idx           (idx),
    .flags         (flags),
    .threshold     (threshold),
    .max_line_width(max_line_width),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .result        (result)
  );

  assign m_tdata = {1'b0, result.position_x2, result.line_index};
  assign m_tuser = result.found;
  assign m_tlast = result.frame_last;

  // a result without a peak above threshold carries position zero
  `LLPS_ASSERT(a_pos_zero_not_found, (m_tvalid && !m_tuser) |-> (m_tdata[22:11] == '0))
  // input held back only behind a stalled result
  `LLPS_ASSERT(a_ready_only_stalled, !s_tready |-> (m_tvalid && !m_tready))
  // no result straight after reset
  `LLPS_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)

endmodule
